/* hw/rtl/shsq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shsq_pkg
// shared types and constants for the stereo half-width squeeze block
// ----------------------------------------------------------------------------
package shsq_pkg;

  localparam int unsigned MAX_ROW_WIDTH_DEF = 4096;

  localparam int unsigned COL_W    = 12;
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned SWIDTH_W = 13;
  localparam int unsigned SHIFT_W  = 14;
  localparam int unsigned TAP_W    = 16;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  localparam logic [SWIDTH_W-1:0] SWIDTH_RST = SWIDTH_W'(4096);
  localparam logic [PIX_W-1:0]    LOW_BIT_CLEAR = 32'hFEFE_FEFE;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic EYE_LEFT  = 1'b0;
  localparam logic EYE_RIGHT = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [1:0] REG_SOURCE_WIDTH = 2'd0;
  localparam logic [1:0] REG_SHIFT_LEFT   = 2'd1;
  localparam logic [1:0] REG_SHIFT_RIGHT  = 2'd2;

  typedef struct packed {
    logic             operation;
    logic [COL_W-1:0] column;
    logic             eye;
    logic [PIX_W-1:0] source_pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             status;
  } out_t;

  function automatic logic [PIX_W-1:0] byte_floor_avg(input logic [PIX_W-1:0] p,
                                                      input logic [PIX_W-1:0] q);
    byte_floor_avg = (p & q) + (((p ^ q) & LOW_BIT_CLEAR) >> 1);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/stereo_half_width_squeeze.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_half_width_squeeze
// horizontal 2:1 box downscale of one source row, per-eye parallax shift
// ----------------------------------------------------------------------------
// usage:
//   in_item is taken at a rising edge with start high and busy low. busy
//   stays low, so one item can be issued every cycle.
//   a write item stores source_pixel at its column when that column lies
//   inside the row; it gives no result.
//   a read item gives one result: out_valid is high for exactly one cycle
//   with out_item. the tap stage reads both taps from the two read ports
//   of the row store into registers; the result stage averages them (or
//   copies a lone tap, or gives an error) and registers the result.
//   the receiver cannot stall; a result is gone after its strobe cycle.
//   registers sit on the apb port: source_width at 0x0, shift_left at 0x4,
//   shift_right at 0x8; write them only while no read is in flight.
//   reset sets source_width to 4096 and both shifts to 0 and drops any
//   item in flight. the row store is not cleared: every column must be
//   written before it is read.
// ----------------------------------------------------------------------------
module stereo_half_width_squeeze #(
  parameter int unsigned MAX_ROW_WIDTH = shsq_pkg::MAX_ROW_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  shsq_pkg::in_t                    in_item,
  output logic                             out_valid,
  output shsq_pkg::out_t                   out_item,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [shsq_pkg::ADDR_W-1:0]      paddr,
  input  wire  [shsq_pkg::DATA_W-1:0]      pwdata,
  output logic [shsq_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int unsigned AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int unsigned TW = shsq_pkg::TAP_W;

  // config registers
  logic [shsq_pkg::SWIDTH_W-1:0] swidth_r;
  logic [shsq_pkg::SHIFT_W-1:0]  shl_r;
  logic [shsq_pkg::SHIFT_W-1:0]  shr_r;
  logic                          cfg_wr;

  // row store
  logic [shsq_pkg::PIX_W-1:0] row_mem [MAX_ROW_WIDTH];
  logic [shsq_pkg::PIX_W-1:0] rd_a_r;
  logic [shsq_pkg::PIX_W-1:0] rd_b_r;

  // tap stage
  logic                       take;
  logic signed [TW-1:0]       live_w;
  logic signed [TW-1:0]       half_w;
  logic signed [TW-1:0]       col_x;
  logic signed [TW-1:0]       shift_x;
  logic signed [TW-1:0]       tap_a;
  logic signed [TW-1:0]       tap_b;
  logic signed [TW-1:0]       clp_a;
  logic signed [TW-1:0]       clp_b;
  logic [AW-1:0]              addr_a;
  logic [AW-1:0]              addr_b;
  logic [AW-1:0]              addr_w;
  logic                       wr_en;
  logic                       rd_vld_nxt;
  logic                       rd_err_nxt;
  logic                       rd_same_nxt;
  logic                       rd_vld_r;
  logic                       rd_err_r;
  logic                       rd_same_r;

  // result stage
  logic                       out_valid_nxt;
  shsq_pkg::out_t             out_item_nxt;
  logic                       out_valid_r;
  shsq_pkg::out_t             out_item_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign take   = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swidth_r <= shsq_pkg::SWIDTH_RST;
      shl_r    <= '0;
      shr_r    <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        shsq_pkg::REG_SOURCE_WIDTH: swidth_r <= pwdata[shsq_pkg::SWIDTH_W-1:0];
        shsq_pkg::REG_SHIFT_LEFT:   shl_r    <= pwdata[shsq_pkg::SHIFT_W-1:0];
        shsq_pkg::REG_SHIFT_RIGHT:  shr_r    <= pwdata[shsq_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      shsq_pkg::REG_SOURCE_WIDTH:
        prdata = {{(shsq_pkg::DATA_W-shsq_pkg::SWIDTH_W){1'b0}}, swidth_r};
      shsq_pkg::REG_SHIFT_LEFT:
        prdata = {{(shsq_pkg::DATA_W-shsq_pkg::SHIFT_W){shl_r[shsq_pkg::SHIFT_W-1]}}, shl_r};
      shsq_pkg::REG_SHIFT_RIGHT:
        prdata = {{(shsq_pkg::DATA_W-shsq_pkg::SHIFT_W){shr_r[shsq_pkg::SHIFT_W-1]}}, shr_r};
      default:
        prdata = '0;
    endcase
  end

  // live width, half width and clamped taps
  always_comb begin
    if ({{(TW-shsq_pkg::SWIDTH_W){1'b0}}, swidth_r} > TW'(MAX_ROW_WIDTH)) begin
      live_w = TW'(MAX_ROW_WIDTH);
    end else begin
      live_w = {{(TW-shsq_pkg::SWIDTH_W){1'b0}}, swidth_r};
    end
    half_w = live_w >>> 1;
    col_x  = {{(TW-shsq_pkg::COL_W){1'b0}}, in_item.column};
    if (in_item.eye == shsq_pkg::EYE_RIGHT) begin
      shift_x = {{(TW-shsq_pkg::SHIFT_W){shr_r[shsq_pkg::SHIFT_W-1]}}, shr_r};
    end else begin
      shift_x = {{(TW-shsq_pkg::SHIFT_W){shl_r[shsq_pkg::SHIFT_W-1]}}, shl_r};
    end
    tap_a = (col_x <<< 1) + shift_x;
    tap_b = tap_a + TW'(1);
    if (tap_a < 0) begin
      clp_a = '0;
    end else if (tap_a > live_w - TW'(1)) begin
      clp_a = live_w - TW'(1);
    end else begin
      clp_a = tap_a;
    end
    if (tap_b < 0) begin
      clp_b = '0;
    end else if (tap_b > live_w - TW'(1)) begin
      clp_b = live_w - TW'(1);
    end else begin
      clp_b = tap_b;
    end
    addr_a      = clp_a[AW-1:0];
    addr_b      = clp_b[AW-1:0];
    addr_w      = col_x[AW-1:0];
    wr_en       = take && (in_item.operation == shsq_pkg::OP_WRITE) && (col_x < live_w);
    rd_vld_nxt  = take && (in_item.operation == shsq_pkg::OP_READ);
    rd_err_nxt  = col_x >= half_w;
    rd_same_nxt = clp_a == clp_b;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[addr_w] <= in_item.source_pixel;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= row_mem[addr_a];
  end

  always_ff @(posedge clk) begin
    rd_b_r <= row_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_vld_nxt;
    end
    rd_err_r  <= rd_err_nxt;
    rd_same_r <= rd_same_nxt;
  end

  // average or copy, or zero pixel on error
  always_comb begin
    out_valid_nxt = rd_vld_r;
    if (rd_err_r) begin
      out_item_nxt.out_pixel = '0;
      out_item_nxt.status    = shsq_pkg::STATUS_ERR;
    end else if (rd_same_r) begin
      out_item_nxt.out_pixel = rd_a_r;
      out_item_nxt.status    = shsq_pkg::STATUS_OK;
    end else begin
      out_item_nxt.out_pixel = shsq_pkg::byte_floor_avg(rd_a_r, rd_b_r);
      out_item_nxt.status    = shsq_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_read_issues: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_item.operation == shsq_pkg::OP_READ) |=> rd_vld_r)
    else $error("read transfer did not reach the tap stage");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_item.operation == shsq_pkg::OP_WRITE) |=> ##1 !out_valid)
    else $error("write transfer produced a result");

  a_stage_chain: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |=> out_valid)
    else $error("tap stage result lost");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == shsq_pkg::STATUS_ERR) |-> (out_item.out_pixel == '0))
    else $error("error result carries a nonzero pixel");

  a_taps_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_item.operation == shsq_pkg::OP_READ && live_w > TW'(1)) |->
      (clp_b == clp_a || clp_b == clp_a + TW'(1)))
    else $error("clamped taps out of order");

endmodule
`default_nettype wire
